### hdl/sm83_load_unit_macros.svh
// Assertion macros for the SM83 load unit.
// Used by files that carry concurrent checks; relies on clk and arst_n in scope.
`ifndef SM83_LOAD_UNIT_MACROS_SVH
`define SM83_LOAD_UNIT_MACROS_SVH
// Plain invariant, sampled on clk, off during reset.
`define SM83LU_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define SM83LU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### hdl/sm83lu_pkg.sv
// Shared types and codes for the SM83 load unit.
// No dependencies; used by sm83lu_regfile, sm83lu_exec and sm83_load_unit.
package sm83lu_pkg;

	typedef enum logic [3:0] {
		MODE_SP      = 4'd0,
		MODE_REL_16  = 4'd1,
		MODE_IMM_16  = 4'd2,
		MODE_IMM     = 4'd3,
		MODE_REG     = 4'd4,
		MODE_MEM_HL  = 4'd5,
		MODE_MEM_R16 = 4'd6,
		MODE_MEM_DI  = 4'd7,
		MODE_MEM_IMM = 4'd8,
		MODE_HIGH    = 4'd9
	} mode_t;

	localparam logic       KIND_INSTR   = 1'b0;
	localparam logic       KIND_DATA    = 1'b1;

	localparam logic [2:0] VAR_HL_INC   = 3'd1;
	localparam logic [2:0] VAR_HL_DEC   = 3'd2;
	localparam logic [2:0] VAR_HIGH_C   = 3'd3;
	localparam logic [2:0] VAR_HIGH_IMM = 3'd4;

	localparam logic [3:0] DEST_BC      = 4'd8;
	localparam logic [3:0] DEST_HL      = 4'd10;
	localparam logic [3:0] DEST_SP      = 4'd11;
	localparam logic [3:0] DEST_NONE    = 4'd15;

	localparam logic [2:0] REG_A        = 3'd7;

	localparam logic [1:0] ROW_BC       = 2'd0;
	localparam logic [1:0] ROW_HL       = 2'd2;
	localparam logic [1:0] ROW_SP       = 2'd3;

	localparam logic [7:0] HIGH_PAGE    = 8'hFF;
	localparam int         RF_ROWS      = 4;

	typedef struct packed {
		logic        opcode;
		logic [3:0]  ld_mode;
		logic [2:0]  variant;
		logic [7:0]  instr_byte;
		logic [7:0]  imm_lo;
		logic [7:0]  imm_hi;
		logic [7:0]  read_data;
	} item_t;

	typedef struct packed {
		logic        read_request;
		logic [15:0] read_address;
		logic [3:0]  dest_index;
		logic [15:0] dest_value;
		logic [3:0]  flags;
		logic [15:0] hl_value;
		logic        error;
	} result_t;

	// one write into the byte-register memory, a row holds two byte registers
	typedef struct packed {
		logic        en;
		logic [1:0]  row;
		logic [1:0]  be;
		logic [15:0] data;
	} rf_wr_t;

	// state kept in flops next to the memory
	typedef struct packed {
		logic [15:0] hl;
		logic [15:0] sp;
		logic [3:0]  flags;
		logic        pending;
		logic [2:0]  pdest;
	} arch_t;

	// memory row an instruction needs, chosen from the item alone
	function automatic logic [1:0] rd_row(input item_t it);
		logic [1:0] r;
		r = ROW_BC;
		case (it.ld_mode)
			MODE_REG:     r = it.instr_byte[2:1];
			MODE_MEM_R16: r = it.instr_byte[5:4];
			default:      r = ROW_BC;
		endcase
		return r;
	endfunction

endpackage

### hdl/sm83lu_regfile.sv
// Byte-register memory for the SM83 load unit: 4 rows of two bytes, one read port
// with registered data, one byte-enable write port, write forwarding. Uses sm83lu_pkg.
module sm83lu_regfile (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [1:0]           rd_addr,
	output logic [15:0]          rd_data,
	input  sm83lu_pkg::rf_wr_t   wr
);

	logic [15:0]                    mem [sm83lu_pkg::RF_ROWS];
	logic [15:0]                    rdata_q;
	logic [1:0]                     rd_row_q;
	sm83lu_pkg::rf_wr_t             fwd_q;
	logic [sm83lu_pkg::RF_ROWS-1:0][1:0] valid_q;
	logic                           hit_hi;
	logic                           hit_lo;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			if (wr.be[1])
				mem[wr.row][15:8] <= wr.data[15:8];
			if (wr.be[0])
				mem[wr.row][7:0] <= wr.data[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q  <= mem[rd_addr];
			rd_row_q <= rd_addr;
		end
	end

	// last write covers a read that landed on the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q   <= '0;
			valid_q <= '0;
		end else if (wr.en) begin
			fwd_q           <= wr;
			valid_q[wr.row] <= valid_q[wr.row] | wr.be;
		end
	end

	assign hit_hi = fwd_q.en && (fwd_q.row == rd_row_q) && fwd_q.be[1];
	assign hit_lo = fwd_q.en && (fwd_q.row == rd_row_q) && fwd_q.be[0];

	// bytes never written read as zero
	assign rd_data[15:8] = (hit_hi ? fwd_q.data[15:8] : rdata_q[15:8])
		& {8{valid_q[rd_row_q][1]}};
	assign rd_data[7:0]  = (hit_lo ? fwd_q.data[7:0] : rdata_q[7:0])
		& {8{valid_q[rd_row_q][0]}};

endmodule

### hdl/sm83lu_exec.sv
// Execute logic of the SM83 load unit: decodes one item against the row read from
// memory and the flop state, giving the result, next state and write-back. Uses sm83lu_pkg.
module sm83lu_exec (
	input  sm83lu_pkg::item_t    item,
	input  logic [15:0]          rdata,
	input  sm83lu_pkg::arch_t    cur,
	output sm83lu_pkg::arch_t    nxt,
	output sm83lu_pkg::result_t  res,
	output sm83lu_pkg::rf_wr_t   wr
);

	logic [1:0]  row;
	logic [2:0]  dst;
	logic [2:0]  src;
	logic [7:0]  src_val;
	logic [15:0] pair_val;
	logic [4:0]  h_sum;
	logic [8:0]  c_sum;
	logic [15:0] rel_sum;
	logic        bw_en;
	logic [2:0]  bw_idx;
	logic [7:0]  bw_val;
	logic        pw_en;
	logic [1:0]  pw_row;
	logic [15:0] pw_val;
	logic        ex_req;
	logic [15:0] ex_addr;
	logic [3:0]  ex_didx;
	logic [15:0] ex_dval;
	logic        ex_err;
	logic        ex_pend;
	logic [2:0]  ex_pdest;
	logic [3:0]  ex_flags;
	logic [7:0]  high_lo;

	assign row = item.instr_byte[5:4];
	assign dst = item.instr_byte[5:3];
	assign src = item.instr_byte[2:0];

	always_comb begin
		if (src[2:1] == sm83lu_pkg::ROW_HL)
			src_val = src[0] ? cur.hl[7:0] : cur.hl[15:8];
		else
			src_val = src[0] ? rdata[7:0] : rdata[15:8];
	end

	always_comb begin
		case (row)
			sm83lu_pkg::ROW_HL: pair_val = cur.hl;
			sm83lu_pkg::ROW_SP: pair_val = cur.sp;
			default:            pair_val = rdata;
		endcase
	end

	assign h_sum   = {1'b0, cur.sp[3:0]} + {1'b0, item.imm_lo[3:0]};
	assign c_sum   = {1'b0, cur.sp[7:0]} + {1'b0, item.imm_lo};
	assign rel_sum = cur.sp + {{8{item.imm_lo[7]}}, item.imm_lo};

	always_comb begin
		if (item.variant == sm83lu_pkg::VAR_HIGH_C)
			high_lo = rdata[7:0];
		else if (item.variant == sm83lu_pkg::VAR_HIGH_IMM)
			high_lo = item.imm_lo;
		else
			high_lo = 8'h00;
	end

	always_comb begin
		bw_en    = 1'b0;
		bw_idx   = '0;
		bw_val   = '0;
		pw_en    = 1'b0;
		pw_row   = '0;
		pw_val   = '0;
		ex_req   = 1'b0;
		ex_addr  = '0;
		ex_didx  = sm83lu_pkg::DEST_NONE;
		ex_dval  = '0;
		ex_err   = 1'b0;
		ex_pend  = cur.pending;
		ex_pdest = cur.pdest;
		ex_flags = cur.flags;
		if (item.opcode == sm83lu_pkg::KIND_DATA) begin
			if (cur.pending) begin
				bw_en   = 1'b1;
				bw_idx  = cur.pdest;
				bw_val  = item.read_data;
				ex_didx = {1'b0, cur.pdest};
				ex_dval = {8'h00, item.read_data};
				ex_pend = 1'b0;
			end else begin
				ex_err = 1'b1;
			end
		end else begin
			ex_pend = 1'b0;
			case (item.ld_mode)
				sm83lu_pkg::MODE_SP: begin
					pw_en   = 1'b1;
					pw_row  = sm83lu_pkg::ROW_SP;
					pw_val  = cur.hl;
					ex_didx = sm83lu_pkg::DEST_SP;
					ex_dval = cur.hl;
				end
				sm83lu_pkg::MODE_REL_16: begin
					ex_flags = {2'b00, h_sum[4], c_sum[8]};
					pw_en    = 1'b1;
					pw_row   = sm83lu_pkg::ROW_HL;
					pw_val   = rel_sum;
					ex_didx  = sm83lu_pkg::DEST_HL;
					ex_dval  = rel_sum;
				end
				sm83lu_pkg::MODE_IMM_16: begin
					pw_en   = 1'b1;
					pw_row  = row;
					pw_val  = {item.imm_hi, item.imm_lo};
					ex_didx = sm83lu_pkg::DEST_BC + {2'b00, row};
					ex_dval = {item.imm_hi, item.imm_lo};
				end
				sm83lu_pkg::MODE_IMM: begin
					bw_en   = 1'b1;
					bw_idx  = {row, item.instr_byte[3]};
					bw_val  = item.imm_lo;
					ex_didx = {1'b0, row, item.instr_byte[3]};
					ex_dval = {8'h00, item.imm_lo};
				end
				sm83lu_pkg::MODE_REG: begin
					bw_en   = 1'b1;
					bw_idx  = dst;
					bw_val  = src_val;
					ex_didx = {1'b0, dst};
					ex_dval = {8'h00, src_val};
				end
				sm83lu_pkg::MODE_MEM_HL: begin
					ex_req   = 1'b1;
					ex_addr  = cur.hl;
					ex_pend  = 1'b1;
					ex_pdest = dst;
				end
				sm83lu_pkg::MODE_MEM_R16: begin
					ex_req   = 1'b1;
					ex_addr  = pair_val;
					ex_pend  = 1'b1;
					ex_pdest = sm83lu_pkg::REG_A;
				end
				sm83lu_pkg::MODE_MEM_DI: begin
					ex_req   = 1'b1;
					ex_addr  = cur.hl;
					ex_pend  = 1'b1;
					ex_pdest = sm83lu_pkg::REG_A;
					pw_row   = sm83lu_pkg::ROW_HL;
					if (item.variant == sm83lu_pkg::VAR_HL_INC) begin
						pw_en  = 1'b1;
						pw_val = cur.hl + 16'd1;
					end else if (item.variant == sm83lu_pkg::VAR_HL_DEC) begin
						pw_en  = 1'b1;
						pw_val = cur.hl - 16'd1;
					end
				end
				sm83lu_pkg::MODE_MEM_IMM: begin
					ex_req   = 1'b1;
					ex_addr  = {item.imm_hi, item.imm_lo};
					ex_pend  = 1'b1;
					ex_pdest = sm83lu_pkg::REG_A;
				end
				sm83lu_pkg::MODE_HIGH: begin
					ex_req   = 1'b1;
					ex_addr  = {sm83lu_pkg::HIGH_PAGE, high_lo};
					ex_pend  = 1'b1;
					ex_pdest = sm83lu_pkg::REG_A;
				end
				default: begin
					ex_err = 1'b1;
				end
			endcase
		end
	end

	// route byte and pair writes: H, L and SP live in flops, the rest in memory
	always_comb begin
		nxt         = cur;
		nxt.flags   = ex_flags;
		nxt.pending = ex_pend;
		nxt.pdest   = ex_pdest;
		wr          = '0;
		if (bw_en) begin
			if (bw_idx[2:1] == sm83lu_pkg::ROW_HL) begin
				if (bw_idx[0])
					nxt.hl[7:0] = bw_val;
				else
					nxt.hl[15:8] = bw_val;
			end else begin
				wr.en   = 1'b1;
				wr.row  = bw_idx[2:1];
				wr.be   = bw_idx[0] ? 2'b01 : 2'b10;
				wr.data = {bw_val, bw_val};
			end
		end
		if (pw_en) begin
			case (pw_row)
				sm83lu_pkg::ROW_HL: nxt.hl = pw_val;
				sm83lu_pkg::ROW_SP: nxt.sp = pw_val;
				default: begin
					wr.en   = 1'b1;
					wr.row  = pw_row;
					wr.be   = 2'b11;
					wr.data = pw_val;
				end
			endcase
		end
	end

	always_comb begin
		res              = '0;
		res.read_request = ex_req;
		res.read_address = ex_addr;
		res.dest_index   = ex_didx;
		res.dest_value   = ex_dval;
		res.flags        = nxt.flags;
		res.hl_value     = nxt.hl;
		res.error        = ex_err;
	end

endmodule

### hdl/sm83_load_unit.sv
// Top level of the SM83 load unit: input stage, register-file memory, execute, output register.
// Depends on sm83lu_pkg, sm83lu_regfile, sm83lu_exec and sm83_load_unit_macros.svh.
//
// Takes one item per clock while the output side does not stall and returns exactly one result
// per item through the input stage and the output register. At the input transfer the unit
// reads one row (two byte registers) of a 4x16 synchronous memory holding B,C / D,E /
// scratch,A; the execute stage then combines that row with H, L, SP, flags and the pending
// read held in flops and, when not stalled, writes back and loads the output register. A write
// that lands on the same edge as a read of its row is forwarded. Per-byte valid flops make
// unwritten registers read as zero, so no clearing pass follows reset. A memory-form
// instruction returns the read address; the following data item completes the load.
`include "sm83_load_unit_macros.svh"

module sm83_load_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  sm83lu_pkg::item_t    item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output sm83lu_pkg::result_t  result
);

	logic                 accept;
	logic                 advance;
	logic                 valid_s1;
	sm83lu_pkg::item_t    item_s1;
	logic [15:0]          rd_data;
	sm83lu_pkg::arch_t    arch_q;
	sm83lu_pkg::arch_t    arch_nxt;
	sm83lu_pkg::result_t  exec_res;
	sm83lu_pkg::rf_wr_t   exec_wr;
	sm83lu_pkg::rf_wr_t   rf_wr;
	logic                 result_valid_q;
	sm83lu_pkg::result_t  result_q;

	assign advance    = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item;
	end

	sm83lu_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (sm83lu_pkg::rd_row(item)),
		.rd_data (rd_data),
		.wr      (rf_wr)
	);

	sm83lu_exec u_exec (
		.item  (item_s1),
		.rdata (rd_data),
		.cur   (arch_q),
		.nxt   (arch_nxt),
		.res   (exec_res),
		.wr    (exec_wr)
	);

	always_comb begin
		rf_wr    = exec_wr;
		rf_wr.en = exec_wr.en && valid_s1 && advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			arch_q <= '0;
		else if (valid_s1 && advance)
			arch_q <= arch_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (advance)
			result_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance)
			result_q <= exec_res;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`SM83LU_ASSERT(a_no_err_with_req, !(result_valid_q && result_q.error && result_q.read_request), "read request flagged as error")
	`SM83LU_ASSERT(a_none_zero, !(result_valid_q && result_q.dest_index == sm83lu_pkg::DEST_NONE && result_q.dest_value != 16'h0000), "value without destination")
	`SM83LU_ASSERT_NEXT(a_req_pends, valid_s1 && advance && exec_res.read_request, arch_q.pending, "read request did not leave a pending load")
	`SM83LU_ASSERT_NEXT(a_stray_data, valid_s1 && advance && item_s1.opcode == sm83lu_pkg::KIND_DATA && !arch_q.pending, result_valid_q && result_q.error, "stray data not flagged")
	`SM83LU_ASSERT_NEXT(a_accept_fills, accept, valid_s1, "transfer in did not fill the input stage")

endmodule
